### hdl/jdpr_pkg.sv
// Package for the joystick dot position block: types, register indexes, constants.
package jdpr_pkg;

   localparam int SampleWidth  = 10;
   localparam int RepeatWidth  = 8;
   localparam int PatternWidth = 8;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 10;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_WAIT  = 2'd1,
      MODE_LOW   = 2'd2,
      MODE_HIGH  = 2'd3
   } mode_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_X_LOW    = 3'd0,
      CSR_X_HIGH   = 3'd1,
      CSR_Y_LOW    = 3'd2,
      CSR_Y_HIGH   = 3'd3,
      CSR_X_REPEAT = 3'd4,
      CSR_Y_REPEAT = 3'd5
   } csr_index_type;

   localparam logic [SampleWidth-1:0]  XLowReset    = 10'h203;
   localparam logic [SampleWidth-1:0]  XHighReset   = 10'h20D;
   localparam logic [SampleWidth-1:0]  YLowReset    = 10'd510;
   localparam logic [SampleWidth-1:0]  YHighReset   = 10'd520;
   localparam logic [RepeatWidth-1:0]  RepeatReset  = 8'd2;
   localparam logic [PatternWidth-1:0] ColumnReset  = 8'h80;
   localparam logic [PatternWidth-1:0] RowReset     = 8'h1E;
   localparam logic [PatternWidth-1:0] ColumnLeftEdge  = 8'h80;
   localparam logic [PatternWidth-1:0] ColumnRightEdge = 8'h01;
   localparam logic [PatternWidth-1:0] RowDownEdge  = 8'hEF;
   localparam logic [PatternWidth-1:0] RowUpEdge    = 8'hFE;

   typedef struct packed {
      logic [SampleWidth-1:0] x_sample;
      logic [SampleWidth-1:0] y_sample;
   } req_type;

   typedef struct packed {
      logic [PatternWidth-1:0] column_drive;
      logic [PatternWidth-1:0] row_drive;
   } rsp_type;

   typedef struct packed {
      logic [RepeatWidth-1:0] count;
      logic                   step_low;
      logic                   step_high;
   } axis_act_type;

endpackage

### hdl/joystick_dot_position_repeat.sv
// Top level: joystick-driven LED matrix dot position with per-axis auto-repeat.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  req     | req_valid req_ready req_data   | in
//  rsp     | rsp_valid rsp_ready rsp_data   | out
//  csr     | csr_we csr_index csr_wdata     | in
//
// One transfer per cycle: each sample pair updates both axis machines and
// patterns in the accept cycle; the result sits in the output register.
// req_ready is high while the output register is empty or being drained.
// Reset restores thresholds, repeat counts, modes, counts and patterns.
module joystick_dot_position_repeat (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  jdpr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output jdpr_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [jdpr_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [jdpr_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import jdpr_pkg::*;

   logic [SampleWidth-1:0]  x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [RepeatWidth-1:0]  x_rep_ff, y_rep_ff;
   mode_type                x_mode_ff, x_mode_in, y_mode_ff, y_mode_in;
   logic [RepeatWidth-1:0]  x_cnt_ff, y_cnt_ff;
   logic [PatternWidth-1:0] col_ff, col_in, row_ff, row_in;
   logic                    started_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff, rsp_data_in;
   axis_act_type            x_act, y_act;
   logic                    accept;
   logic                    x_below, x_above, y_below, y_above;

   function automatic mode_type next_mode(mode_type m, logic below, logic above);
      mode_type r;
      r = m;
      unique case (m)
         MODE_START: r = MODE_WAIT;
         MODE_WAIT: begin
            if (below) r = MODE_LOW;
            else if (above) r = MODE_HIGH;
         end
         MODE_LOW:  if (!below) r = MODE_WAIT;
         MODE_HIGH: if (!above) r = MODE_WAIT;
         default:   r = MODE_WAIT;
      endcase
      return r;
   endfunction

   function automatic axis_act_type axis_action(mode_type m, logic below, logic above,
                                                logic [RepeatWidth-1:0] cnt,
                                                logic [RepeatWidth-1:0] rep);
      axis_act_type           a;
      logic [RepeatWidth-1:0] inc;
      inc = cnt + 1'b1;
      a.count = cnt;
      a.step_low = 1'b0;
      a.step_high = 1'b0;
      unique case (m)
         MODE_START: a.count = cnt;
         MODE_WAIT:  if (below || above) a.count = inc;
         MODE_LOW: begin
            if (!below) a.count = '0;
            else if (inc >= rep) begin
               a.count = '0;
               a.step_low = 1'b1;
            end else a.count = inc;
         end
         MODE_HIGH: begin
            if (!above) a.count = '0;
            else if (inc >= rep) begin
               a.count = '0;
               a.step_high = 1'b1;
            end else a.count = inc;
         end
         default: a.count = cnt;
      endcase
      return a;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign x_below = req_data.x_sample < x_low_ff;
   assign x_above = req_data.x_sample > x_high_ff;
   assign y_below = req_data.y_sample < y_low_ff;
   assign y_above = req_data.y_sample > y_high_ff;

   // next state
   always_comb begin
      x_mode_in = next_mode(x_mode_ff, x_below, x_above);
      y_mode_in = next_mode(y_mode_ff, y_below, y_above);
   end

   // outputs of the axis machines
   always_comb begin
      x_act = axis_action(x_mode_ff, x_below, x_above, x_cnt_ff, x_rep_ff);
      y_act = axis_action(y_mode_ff, y_below, y_above, y_cnt_ff, y_rep_ff);
   end

   always_comb begin
      col_in = col_ff;
      if (x_act.step_low && col_ff != ColumnLeftEdge) col_in = {col_ff[PatternWidth-2:0], 1'b0};
      else if (x_act.step_high && col_ff != ColumnRightEdge)
         col_in = {1'b0, col_ff[PatternWidth-1:1]};
      row_in = row_ff;
      if (y_act.step_low && row_ff != RowDownEdge) row_in = {row_ff[PatternWidth-2:0], 1'b1};
      else if (y_act.step_high && row_ff != RowUpEdge) row_in = {1'b1, row_ff[PatternWidth-1:1]};
      rsp_data_in.column_drive = started_ff ? col_in : '0;
      rsp_data_in.row_drive    = started_ff ? row_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= XLowReset;
         x_high_ff <= XHighReset;
         y_low_ff  <= YLowReset;
         y_high_ff <= YHighReset;
         x_rep_ff  <= RepeatReset;
         y_rep_ff  <= RepeatReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_LOW:    x_low_ff  <= csr_wdata[SampleWidth-1:0];
            CSR_X_HIGH:   x_high_ff <= csr_wdata[SampleWidth-1:0];
            CSR_Y_LOW:    y_low_ff  <= csr_wdata[SampleWidth-1:0];
            CSR_Y_HIGH:   y_high_ff <= csr_wdata[SampleWidth-1:0];
            CSR_X_REPEAT: x_rep_ff  <= csr_wdata[RepeatWidth-1:0];
            CSR_Y_REPEAT: y_rep_ff  <= csr_wdata[RepeatWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_mode_ff    <= MODE_START;
         y_mode_ff    <= MODE_START;
         x_cnt_ff     <= '0;
         y_cnt_ff     <= '0;
         col_ff       <= ColumnReset;
         row_ff       <= RowReset;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            x_mode_ff  <= x_mode_in;
            y_mode_ff  <= y_mode_in;
            x_cnt_ff   <= x_act.count;
            y_cnt_ff   <= y_act.count;
            col_ff     <= col_in;
            row_ff     <= row_in;
            started_ff <= 1'b1;
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule
